>>> design/scq_pkg.sv
// Shared types and constants of the similarity query result cache.
`default_nettype none
package scq_pkg;

	localparam int ELEM_W  = 16;
	localparam int KEY_W   = 64;
	localparam int DIST_W  = 32;
	localparam int LABEL_W = 32;
	localparam int ACC_W   = 48;
	localparam int SQ_W    = 2 * (ELEM_W + 1);

	localparam int CAP_W  = 5;
	localparam int THR_W  = 48;
	localparam int DIMR_W = 7;
	localparam int KR_W   = 5;
	localparam int CFG_W  = 48;

	localparam logic [1:0] CFG_CAPACITY     = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD    = 2'd1;
	localparam logic [1:0] CFG_DIM_IN_USE   = 2'd2;
	localparam logic [1:0] CFG_RESULT_COUNT = 2'd3;

	localparam logic [1:0] KIND_ELEM  = 2'd0;
	localparam logic [1:0] KIND_FILL  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [CAP_W-1:0]  CAP_RST = 5'd16;
	localparam logic [THR_W-1:0]  THR_RST = 48'd655;
	localparam logic [DIMR_W-1:0] DIM_RST = 7'd64;
	localparam logic [KR_W-1:0]   K_RST   = 5'd16;

	// Element value times 1000 in Q8.8 is q * 125 / 32.
	localparam logic [KEY_W-1:0] KEY_PRIME = 64'd31;
	localparam int T_MUL   = 125;
	localparam int T_SHIFT = 5;
	localparam int T_W     = 24;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD,
		ST_SEARCH,
		ST_DIST,
		ST_DECIDE,
		ST_EMIT,
		ST_MISS,
		ST_FSEARCH,
		ST_EVCHK,
		ST_EVSCAN,
		ST_FREESCAN,
		ST_COPY
	} state_t;

	typedef struct packed {
		logic clr;
		logic step;
		logic pad;
	} key_ctl_t;

	typedef struct packed {
		logic clr;
		logic vld;
		logic qzero;
	} dist_ctl_t;

endpackage
`default_nettype wire

>>> design/similarity_query_result_cache_top.sv
// Top level of the similarity query result cache with its sequencer.
// Non-final transactions leave the sequencer idle; a final element adds key padding,
// the entry search, the distance sum, a decision and the results (a miss
// ends sooner with its single result). A final fill adds the entry search, eviction
// rounds that each scan the entries, a search for a free entry and the copy.
// Results cannot be held off. Reset clears control state and loads register defaults.
`default_nettype none
module similarity_query_result_cache_top #(
	parameter int MAX_DIM   = 64,
	parameter int MAX_K     = 16,
	parameter int ENTRIES   = 16,
	parameter int HASH_DIMS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        kind,
	input  wire logic signed [scq_pkg::ELEM_W-1:0] query_element,
	input  wire logic [scq_pkg::DIST_W-1:0]        fill_distance,
	input  wire logic signed [scq_pkg::LABEL_W-1:0] fill_label,
	input  wire logic                              last,
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_index,
	input  wire logic [scq_pkg::CFG_W-1:0]         cfg_data,
	output logic                                   strobe,
	output logic                                   hit,
	output logic [scq_pkg::DIST_W-1:0]             out_distance,
	output logic signed [scq_pkg::LABEL_W-1:0]     out_label,
	output logic                                   last_result,
	output logic [31:0]                            hit_count,
	output logic [31:0]                            miss_count
);
	localparam int IW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DW        = $clog2(MAX_DIM + 1);
	localparam int KI        = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	localparam int KW        = $clog2(MAX_K + 1);
	localparam int EW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW        = $clog2(ENTRIES + 1);
	localparam int COPY_N    = (MAX_DIM > MAX_K) ? MAX_DIM : MAX_K;
	localparam int PW        = $clog2(COPY_N + 1);
	localparam int VEC_DEPTH = ENTRIES << IW;
	localparam int RES_DEPTH = ENTRIES << KI;

	// Configuration registers.
	logic [scq_pkg::CAP_W-1:0]  capacity_q;
	logic [scq_pkg::THR_W-1:0]  threshold_q;
	logic [scq_pkg::DIMR_W-1:0] dim_q;
	logic [scq_pkg::KR_W-1:0]   kreg_q;

	// Sequencer and entry table.
	scq_pkg::state_t            state_q, state_d;
	logic [EW-1:0]              scan_q;
	logic [PW-1:0]              cnt_q;
	logic [DW-1:0]              eidx_q, qlen_q, pad_q;
	logic [scq_pkg::KEY_W-1:0]  qkey_q, pend_key_q, cmp_key;
	logic                       pend_q;
	logic [KW-1:0]              pend_k_q, fcnt_q;
	logic [EW-1:0]              slot_q, lru_q, lru_fin;
	logic                       lru_ok_q;
	logic [ENTRIES-1:0]         valid_q;
	logic [scq_pkg::KEY_W-1:0]  ekey_q [ENTRIES];
	logic [KW-1:0]              ek_q [ENTRIES];
	logic [EW-1:0]              rank_q [ENTRIES];
	logic [CW-1:0]              nvalid_q;
	logic [31:0]                hits_q, misses_q;
	logic                       v_s1, inr_s1, fin_s1;
	logic [PW-1:0]              idx_s1;

	// Clamped registers.
	logic [CW-1:0] cap_c;
	logic [DW-1:0] dim_c, hd_c;
	logic [KW-1:0] k_c;

	// Per-cycle decisions.
	logic accept, elem_ok, fill_ok, clr_ok, elem_fin, fill_fin;
	logic match, scan_last, issue, lru_cand, dist_hit;
	logic tch_en, ins_en;
	logic [EW-1:0] tch_idx;
	logic [DW:0] eidx_nx;
	logic [KW:0] fcnt_nx;

	// Memory ports.
	logic signed [scq_pkg::ELEM_W-1:0]  qb_rdata, vec_rdata, vec_wdata;
	logic [scq_pkg::DIST_W-1:0]         res_d_rdata, stg_d_rdata, res_d_wdata;
	logic [scq_pkg::LABEL_W-1:0]        res_l_rdata, stg_l_rdata, res_l_wdata;
	logic                               qb_we, stg_we, vec_we, res_we;

	scq_pkg::key_ctl_t          key_ctl;
	scq_pkg::dist_ctl_t         dist_ctl;
	logic [scq_pkg::KEY_W-1:0]  run_key;
	logic [scq_pkg::ACC_W-1:0]  dist_acc;
	logic                       dist_pend;

	// Output registers.
	logic                         strobe_q, hit_q, lastr_q;
	logic [scq_pkg::DIST_W-1:0]   odist_q;
	logic [scq_pkg::LABEL_W-1:0]  olabel_q;

	// Registers out of range are clamped to their legal span.
	always_comb begin
		if (capacity_q == '0) begin
			cap_c = CW'(1);
		end else if (int'(capacity_q) > ENTRIES) begin
			cap_c = CW'(ENTRIES);
		end else begin
			cap_c = CW'(capacity_q);
		end
		if (dim_q == '0) begin
			dim_c = DW'(1);
		end else if (int'(dim_q) > MAX_DIM) begin
			dim_c = DW'(MAX_DIM);
		end else begin
			dim_c = DW'(dim_q);
		end
		if (kreg_q == '0) begin
			k_c = KW'(1);
		end else if (int'(kreg_q) > MAX_K) begin
			k_c = KW'(MAX_K);
		end else begin
			k_c = KW'(kreg_q);
		end
		hd_c = (int'(dim_c) < HASH_DIMS) ? dim_c : DW'(HASH_DIMS);
	end

	// Transaction decode. Elements during a pending fill and fills without a
	// pending miss are dropped without any result.
	always_comb begin
		accept   = start && !busy;
		elem_ok  = accept && (kind == scq_pkg::KIND_ELEM) && !pend_q;
		fill_ok  = accept && (kind == scq_pkg::KIND_FILL) && pend_q;
		clr_ok   = accept && (kind == scq_pkg::KIND_CLEAR);
		eidx_nx  = (DW + 1)'(eidx_q) + (DW + 1)'(1);
		fcnt_nx  = (KW + 1)'(fcnt_q) + (KW + 1)'(1);
		elem_fin = elem_ok && (last || (eidx_nx >= (DW + 1)'(dim_c)));
		fill_fin = fill_ok && (last || (fcnt_nx >= (KW + 1)'(pend_k_q)));
	end

	// The key search compares one entry per cycle.
	always_comb begin
		cmp_key   = (state_q == scq_pkg::ST_FSEARCH) ? pend_key_q : qkey_q;
		match     = valid_q[scan_q] && (ekey_q[scan_q] == cmp_key);
		scan_last = (scan_q == EW'(ENTRIES - 1));
		lru_cand  = valid_q[scan_q] && (!lru_ok_q || (rank_q[scan_q] > rank_q[lru_q]));
		lru_fin   = lru_cand ? scan_q : lru_q;
		dist_hit  = (dist_acc <= threshold_q);
	end

	// Next state and per-state controls.
	always_comb begin
		state_d = state_q;
		issue   = 1'b0;
		tch_en  = 1'b0;
		ins_en  = 1'b0;
		tch_idx = scan_q;
		case (state_q)
			scq_pkg::ST_IDLE: begin
				if (elem_fin) begin
					state_d = scq_pkg::ST_PAD;
				end else if (fill_fin) begin
					state_d = scq_pkg::ST_FSEARCH;
				end
			end
			scq_pkg::ST_PAD: begin
				if (pad_q >= hd_c) begin
					state_d = scq_pkg::ST_SEARCH;
				end
			end
			scq_pkg::ST_SEARCH: begin
				if (match) begin
					state_d = (ek_q[scan_q] == k_c) ? scq_pkg::ST_DIST : scq_pkg::ST_MISS;
				end else if (scan_last) begin
					state_d = scq_pkg::ST_MISS;
				end
			end
			scq_pkg::ST_DIST: begin
				issue = (cnt_q < PW'(dim_c));
				if (!issue && !v_s1 && !dist_pend) begin
					state_d = scq_pkg::ST_DECIDE;
				end
			end
			scq_pkg::ST_DECIDE: begin
				tch_idx = slot_q;
				tch_en  = dist_hit;
				state_d = dist_hit ? scq_pkg::ST_EMIT : scq_pkg::ST_MISS;
			end
			scq_pkg::ST_EMIT: begin
				issue = (cnt_q < PW'(k_c));
				if (!issue && !v_s1) begin
					state_d = scq_pkg::ST_IDLE;
				end
			end
			scq_pkg::ST_MISS: begin
				state_d = scq_pkg::ST_IDLE;
			end
			scq_pkg::ST_FSEARCH: begin
				if (match) begin
					tch_en  = 1'b1;
					state_d = scq_pkg::ST_COPY;
				end else if (scan_last) begin
					state_d = scq_pkg::ST_EVCHK;
				end
			end
			scq_pkg::ST_EVCHK: begin
				state_d = (nvalid_q >= cap_c) ? scq_pkg::ST_EVSCAN : scq_pkg::ST_FREESCAN;
			end
			scq_pkg::ST_EVSCAN: begin
				if (scan_last) begin
					state_d = scq_pkg::ST_EVCHK;
				end
			end
			scq_pkg::ST_FREESCAN: begin
				if (!valid_q[scan_q]) begin
					ins_en  = 1'b1;
					state_d = scq_pkg::ST_COPY;
				end
			end
			scq_pkg::ST_COPY: begin
				issue = (cnt_q < PW'(COPY_N));
				if (!issue && !v_s1) begin
					state_d = scq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= scq_pkg::CAP_RST;
			threshold_q <= scq_pkg::THR_RST;
			dim_q       <= scq_pkg::DIM_RST;
			kreg_q      <= scq_pkg::K_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				scq_pkg::CFG_CAPACITY:     capacity_q  <= cfg_data[scq_pkg::CAP_W-1:0];
				scq_pkg::CFG_THRESHOLD:    threshold_q <= cfg_data[scq_pkg::THR_W-1:0];
				scq_pkg::CFG_DIM_IN_USE:   dim_q       <= cfg_data[scq_pkg::DIMR_W-1:0];
				scq_pkg::CFG_RESULT_COUNT: kreg_q      <= cfg_data[scq_pkg::KR_W-1:0];
				default: ;
			endcase
		end
	end

	// Entry contents are only read behind their valid bits.
	always_ff @(posedge clk) begin
		if (state_q == scq_pkg::ST_PAD && pad_q >= hd_c) begin
			qkey_q <= run_key;
		end
		if (state_q == scq_pkg::ST_MISS) begin
			pend_key_q <= qkey_q;
			pend_k_q   <= k_c;
		end
		if (state_q == scq_pkg::ST_FSEARCH && match) begin
			ekey_q[scan_q] <= pend_key_q;
			ek_q[scan_q]   <= pend_k_q;
		end
		if (ins_en) begin
			ekey_q[scan_q] <= pend_key_q;
			ek_q[scan_q]   <= pend_k_q;
		end
		idx_s1 <= cnt_q;
		inr_s1 <= (cnt_q < PW'(qlen_q));
		fin_s1 <= (cnt_q < PW'(fcnt_q));
	end

	// Control state of the sequencer, the entry table and the counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			cnt_q    <= '0;
			eidx_q   <= '0;
			qlen_q   <= '0;
			pad_q    <= '0;
			pend_q   <= 1'b0;
			fcnt_q   <= '0;
			slot_q   <= '0;
			lru_q    <= '0;
			lru_ok_q <= 1'b0;
			valid_q  <= '0;
			nvalid_q <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			v_s1     <= 1'b0;
			for (int j = 0; j < ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			v_s1 <= issue;
			if (state_d != state_q) begin
				scan_q <= '0;
				cnt_q  <= '0;
			end else begin
				scan_q <= scan_q + EW'(1);
				if (issue) begin
					cnt_q <= cnt_q + PW'(1);
				end
			end

			if (clr_ok) begin
				valid_q  <= '0;
				nvalid_q <= '0;
				hits_q   <= '0;
				misses_q <= '0;
				pend_q   <= 1'b0;
				fcnt_q   <= '0;
				eidx_q   <= '0;
				for (int j = 0; j < ENTRIES; j++) begin
					rank_q[j] <= '0;
				end
			end

			if (elem_ok) begin
				if (elem_fin) begin
					eidx_q <= '0;
					qlen_q <= DW'(eidx_nx);
					pad_q  <= DW'(eidx_nx);
				end else begin
					eidx_q <= DW'(eidx_nx);
				end
			end
			if (state_q == scq_pkg::ST_PAD && pad_q < hd_c) begin
				pad_q <= pad_q + DW'(1);
			end

			if (fill_ok) begin
				fcnt_q <= KW'(fcnt_nx);
				if (fill_fin) begin
					pend_q <= 1'b0;
				end
			end

			if ((state_q == scq_pkg::ST_SEARCH || state_q == scq_pkg::ST_FSEARCH) && match) begin
				slot_q <= scan_q;
			end

			if (state_q == scq_pkg::ST_DECIDE && dist_hit && hits_q != '1) begin
				hits_q <= hits_q + 32'd1;
			end
			if (state_q == scq_pkg::ST_MISS) begin
				if (misses_q != '1) begin
					misses_q <= misses_q + 32'd1;
				end
				pend_q <= 1'b1;
				fcnt_q <= '0;
			end

			// Least recently used search: the first entry of the highest rank.
			if (state_q == scq_pkg::ST_EVSCAN) begin
				if (scan_last) begin
					valid_q[lru_fin] <= 1'b0;
					nvalid_q         <= nvalid_q - CW'(1);
					lru_ok_q         <= 1'b0;
				end else if (lru_cand) begin
					lru_q    <= scan_q;
					lru_ok_q <= 1'b1;
				end
			end

			// A touched entry becomes most recent and the younger ones age by one.
			if (tch_en) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (valid_q[j] && EW'(j) != tch_idx && rank_q[j] < rank_q[tch_idx]) begin
						rank_q[j] <= rank_q[j] + EW'(1);
					end
				end
				rank_q[tch_idx] <= '0;
			end

			// A newly inserted entry ages every other one.
			if (ins_en) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (valid_q[j]) begin
						rank_q[j] <= rank_q[j] + EW'(1);
					end
				end
				rank_q[scan_q]  <= '0;
				valid_q[scan_q] <= 1'b1;
				nvalid_q        <= nvalid_q + CW'(1);
				slot_q          <= scan_q;
			end
		end
	end

	// Result registers: a miss gives one empty result, a hit streams k stored results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			hit_q    <= 1'b0;
			lastr_q  <= 1'b0;
			odist_q  <= '0;
			olabel_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (state_q == scq_pkg::ST_MISS) begin
				strobe_q <= 1'b1;
				hit_q    <= 1'b0;
				lastr_q  <= 1'b1;
				odist_q  <= '0;
				olabel_q <= '0;
			end else if (state_q == scq_pkg::ST_EMIT && v_s1) begin
				strobe_q <= 1'b1;
				hit_q    <= 1'b1;
				lastr_q  <= ((PW + 1)'(idx_s1) + (PW + 1)'(1)) == (PW + 1)'(k_c);
				odist_q  <= res_d_rdata;
				olabel_q <= res_l_rdata;
			end
		end
	end

	always_comb begin
		key_ctl.clr  = clr_ok || (state_q == scq_pkg::ST_PAD && pad_q >= hd_c);
		key_ctl.step = elem_ok && (eidx_q < hd_c);
		key_ctl.pad  = (state_q == scq_pkg::ST_PAD) && (pad_q < hd_c);

		dist_ctl.clr   = (state_q == scq_pkg::ST_SEARCH);
		dist_ctl.vld   = (state_q == scq_pkg::ST_DIST) && v_s1;
		dist_ctl.qzero = !inr_s1;

		qb_we  = elem_ok && (int'(eidx_q) < MAX_DIM);
		stg_we = fill_ok && (fcnt_q < pend_k_q) && (int'(fcnt_q) < MAX_K);
		vec_we = (state_q == scq_pkg::ST_COPY) && v_s1 && (int'(idx_s1) < MAX_DIM);
		res_we = (state_q == scq_pkg::ST_COPY) && v_s1 && (int'(idx_s1) < MAX_K);

		// Positions past the received elements and fill items read as empty.
		vec_wdata   = inr_s1 ? qb_rdata : '0;
		res_d_wdata = fin_s1 ? stg_d_rdata : '0;
		res_l_wdata = fin_s1 ? stg_l_rdata : '1;
	end

	scq_key u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (key_ctl),
		.elem   (query_element),
		.key    (run_key)
	);

	scq_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dist_ctl),
		.q_elem (qb_rdata),
		.e_elem (vec_rdata),
		.acc    (dist_acc),
		.pend   (dist_pend)
	);

	scq_ram #(.W(scq_pkg::ELEM_W), .DEPTH(MAX_DIM)) u_qbuf (
		.clk   (clk),
		.we    (qb_we),
		.waddr (eidx_q[IW-1:0]),
		.wdata (query_element),
		.raddr (cnt_q[IW-1:0]),
		.rdata (qb_rdata)
	);

	scq_ram #(.W(scq_pkg::ELEM_W), .DEPTH(VEC_DEPTH)) u_vec (
		.clk   (clk),
		.we    (vec_we),
		.waddr ({slot_q, idx_s1[IW-1:0]}),
		.wdata (vec_wdata),
		.raddr ({slot_q, cnt_q[IW-1:0]}),
		.rdata (vec_rdata)
	);

	scq_ram #(.W(scq_pkg::DIST_W), .DEPTH(MAX_K)) u_stg_dist (
		.clk   (clk),
		.we    (stg_we),
		.waddr (fcnt_q[KI-1:0]),
		.wdata (fill_distance),
		.raddr (cnt_q[KI-1:0]),
		.rdata (stg_d_rdata)
	);

	scq_ram #(.W(scq_pkg::LABEL_W), .DEPTH(MAX_K)) u_stg_label (
		.clk   (clk),
		.we    (stg_we),
		.waddr (fcnt_q[KI-1:0]),
		.wdata (fill_label),
		.raddr (cnt_q[KI-1:0]),
		.rdata (stg_l_rdata)
	);

	scq_ram #(.W(scq_pkg::DIST_W), .DEPTH(RES_DEPTH)) u_res_dist (
		.clk   (clk),
		.we    (res_we),
		.waddr ({slot_q, idx_s1[KI-1:0]}),
		.wdata (res_d_wdata),
		.raddr ({slot_q, cnt_q[KI-1:0]}),
		.rdata (res_d_rdata)
	);

	scq_ram #(.W(scq_pkg::LABEL_W), .DEPTH(RES_DEPTH)) u_res_label (
		.clk   (clk),
		.we    (res_we),
		.waddr ({slot_q, idx_s1[KI-1:0]}),
		.wdata (res_l_wdata),
		.raddr ({slot_q, cnt_q[KI-1:0]}),
		.rdata (res_l_rdata)
	);

	assign busy         = (state_q != scq_pkg::ST_IDLE);
	assign strobe       = strobe_q;
	assign hit          = hit_q;
	assign out_distance = odist_q;
	assign out_label    = olabel_q;
	assign last_result  = lastr_q;
	assign hit_count    = hits_q;
	assign miss_count   = misses_q;

`ifndef ASSERT_OFF
	a_nvalid: assert property (@(posedge clk) disable iff (!arst_n)
		int'(nvalid_q) == $countones(valid_q))
		else $error("valid entry count disagrees with valid bits");
	a_miss_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !hit_q) |-> pend_q)
		else $error("miss result without a pending fill");
	a_copy_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scq_pkg::ST_COPY) |-> valid_q[slot_q])
		else $error("copy into an entry that is not valid");
	a_hit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && hit_q && !lastr_q) |-> busy)
		else $error("hit results stopped before the last one");
`endif

endmodule
`default_nettype wire

>>> design/scq_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module scq_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                                 wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [W-1:0]                                 rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> design/scq_key.sv
// Running query key: key times 31 plus the scaled element, or times 31 alone on padding, wrapping.
`default_nettype none
module scq_key (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire scq_pkg::key_ctl_t             ctl,
	input  wire logic signed [scq_pkg::ELEM_W-1:0] elem,
	output logic [scq_pkg::KEY_W-1:0]          key
);
	logic signed [scq_pkg::T_W-1:0]   prod;
	logic signed [scq_pkg::T_W-1:0]   t;
	logic [scq_pkg::KEY_W-1:0]        key_q;
	logic [scq_pkg::KEY_W-1:0]        mul;

	always_comb begin
		prod = scq_pkg::T_W'(elem) * scq_pkg::T_W'(scq_pkg::T_MUL);
		// Division rounds toward zero, so negative values are biased first.
		if (prod < 0) begin
			t = (prod + scq_pkg::T_W'((1 << scq_pkg::T_SHIFT) - 1)) >>> scq_pkg::T_SHIFT;
		end else begin
			t = prod >>> scq_pkg::T_SHIFT;
		end
		// Times 31 as thirty-two times the key less the key.
		mul = (key_q << 5) - key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (ctl.clr) begin
			key_q <= '0;
		end else if (ctl.step) begin
			key_q <= mul + scq_pkg::KEY_W'(t);
		end else if (ctl.pad) begin
			key_q <= mul;
		end
	end

	assign key = key_q;
endmodule
`default_nettype wire

>>> design/scq_dist.sv
// Squared distance unit: one difference squared and accumulated per cycle.
`default_nettype none
module scq_dist (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire scq_pkg::dist_ctl_t                ctl,
	input  wire logic signed [scq_pkg::ELEM_W-1:0] q_elem,
	input  wire logic signed [scq_pkg::ELEM_W-1:0] e_elem,
	output logic [scq_pkg::ACC_W-1:0]              acc,
	output logic                                   pend
);
	logic signed [scq_pkg::ELEM_W:0]   diff;
	logic signed [scq_pkg::SQ_W-1:0]   sq;
	logic [scq_pkg::SQ_W-1:0]          sq_s2;
	logic                              v_s2;
	logic [scq_pkg::ACC_W:0]           sum;
	logic [scq_pkg::ACC_W-1:0]         acc_q;

	always_comb begin
		diff = (ctl.qzero ? (scq_pkg::ELEM_W + 1)'(0) : (scq_pkg::ELEM_W + 1)'(q_elem))
			- (scq_pkg::ELEM_W + 1)'(e_elem);
		sq   = diff * diff;
		sum  = (scq_pkg::ACC_W + 1)'(acc_q) + (scq_pkg::ACC_W + 1)'(sq_s2);
	end

	always_ff @(posedge clk) begin
		sq_s2 <= $unsigned(sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s2 <= ctl.vld;
			if (ctl.clr) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= sum[scq_pkg::ACC_W] ? '1 : sum[scq_pkg::ACC_W-1:0];
			end
		end
	end

	assign acc  = acc_q;
	assign pend = v_s2;
endmodule
`default_nettype wire

>>> tb/tb_similarity_query_result_cache_top.sv
// Self-checking testbench of the similarity query result cache: directed and random traffic.
`default_nettype none
module tb_similarity_query_result_cache_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Kind code that the block ignores; the package names only the three used ones.
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	// The head of the top level tells of a fill commit with no result: eviction
	// rounds that each scan the entries, plus the copy. This quiet spell covers
	// that with room to spare.
	localparam int SETTLE_CYCLES = 400;
	localparam int CYCLE_LIMIT   = 600000;
	localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]  kind;
		logic [15:0] elem;
		logic [31:0] distance;
		logic [31:0] label;
		logic        fin;
	} cache_txn_t;

	typedef struct {
		logic        hit;
		logic [31:0] distance;
		logic [31:0] label;
		logic        fin;
		logic [31:0] hits;
		logic [31:0] misses;
	} cache_result_t;

	logic clk, arst_n;
	logic start, busy;
	logic [1:0] kind;
	logic signed [scq_pkg::ELEM_W-1:0] query_element;
	logic [scq_pkg::DIST_W-1:0] fill_distance;
	logic signed [scq_pkg::LABEL_W-1:0] fill_label;
	logic last;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [scq_pkg::CFG_W-1:0] cfg_data;
	logic strobe, hit, last_result;
	logic [scq_pkg::DIST_W-1:0] out_distance;
	logic signed [scq_pkg::LABEL_W-1:0] out_label;
	logic [31:0] hit_count, miss_count;

	similarity_query_result_cache_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.query_element(query_element), .fill_distance(fill_distance),
		.fill_label(fill_label), .last(last), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .strobe(strobe), .hit(hit), .out_distance(out_distance),
		.out_label(out_label), .last_result(last_result), .hit_count(hit_count),
		.miss_count(miss_count)
	);

	// Twelve nanosecond clock.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Shadow of the register file, kept at the written widths.
	logic [4:0]  cap_reg;
	logic [47:0] thr_reg;
	logic [6:0]  dim_reg;
	logic [4:0]  k_reg;

	// Shadow of the cache contents and of the query under assembly.
	logic signed [15:0] query_vec [64];
	logic [63:0] query_key;
	int          query_pos;
	logic        slot_valid [16];
	logic [63:0] slot_key [16];
	int          slot_k [16];
	logic signed [15:0] slot_vec [16][64];
	logic [31:0] slot_dist [16][16];
	logic [31:0] slot_label [16][16];
	int          slot_age [16];
	logic        awaiting_fill;
	logic [63:0] miss_key;
	int          miss_k;
	int          fills_seen;
	logic [31:0] staged_dist [16];
	logic [31:0] staged_label [16];
	logic [31:0] hits_seen, misses_seen;

	cache_result_t pending_results [$];
	int errors;
	int cycles;
	logic skip_gaps;

	// Pool of query vectors that are offered again and again, so that hits occur.
	logic signed [15:0] vec_pool [6][64];

	function automatic int clamp_reg(int v, int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int dim_now();
		return clamp_reg(int'(dim_reg), 64);
	endfunction

	function automatic int k_now();
		return clamp_reg(int'(k_reg), 16);
	endfunction

	task automatic reset_shadow();
		cap_reg = scq_pkg::CAP_RST;
		thr_reg = scq_pkg::THR_RST;
		dim_reg = scq_pkg::DIM_RST;
		k_reg   = scq_pkg::K_RST;
		for (int i = 0; i < 64; i++)
			query_vec[i] = '0;
		for (int s = 0; s < 16; s++) begin
			slot_valid[s] = 1'b0;
			slot_age[s]   = 0;
		end
		query_key     = '0;
		query_pos     = 0;
		awaiting_fill = 1'b0;
		fills_seen    = 0;
		hits_seen     = '0;
		misses_seen   = '0;
	endtask

	function automatic int lookup_slot(logic [63:0] key);
		for (int s = 0; s < 16; s++)
			if (slot_valid[s] && slot_key[s] == key)
				return s;
		return -1;
	endfunction

	// Make a slot most recently used; younger valid slots age by one.
	task automatic promote_slot(int s);
		for (int j = 0; j < 16; j++)
			if (slot_valid[j] && j != s && slot_age[j] < slot_age[s])
				slot_age[j]++;
		slot_age[s] = 0;
	endtask

	task automatic store_slot(int s);
		slot_key[s] = miss_key;
		slot_k[s]   = miss_k;
		for (int i = 0; i < 64; i++)
			slot_vec[s][i] = query_vec[i];
		for (int r = 0; r < 16; r++) begin
			slot_dist[s][r]  = staged_dist[r];
			slot_label[s][r] = staged_label[r];
		end
	endtask

	task automatic commit_fill();
		int s;
		int lru;
		int used;
		int cap;
		s = lookup_slot(miss_key);
		if (s >= 0) begin
			store_slot(s);
			promote_slot(s);
			return;
		end
		cap  = clamp_reg(int'(cap_reg), 16);
		used = 0;
		for (int j = 0; j < 16; j++)
			if (slot_valid[j])
				used++;
		while (used >= cap) begin
			lru = -1;
			for (int j = 0; j < 16; j++)
				if (slot_valid[j] && (lru < 0 || slot_age[j] > slot_age[lru]))
					lru = j;
			slot_valid[lru] = 1'b0;
			used--;
		end
		for (int j = 0; j < 16; j++)
			if (!slot_valid[j] && s < 0)
				s = j;
		for (int j = 0; j < 16; j++)
			if (slot_valid[j])
				slot_age[j]++;
		store_slot(s);
		slot_valid[s] = 1'b1;
		slot_age[s]   = 0;
	endtask

	function automatic longint unsigned squared_gap(int s, int dim);
		longint unsigned sum;
		longint d;
		sum = 0;
		for (int i = 0; i < dim; i++) begin
			d = longint'(query_vec[i]) - longint'(slot_vec[s][i]);
			sum += longint'(d * d);
			if (sum > SUM_MAX)
				sum = SUM_MAX;
		end
		return sum;
	endfunction

	// Look the completed query up and queue the results it must produce.
	task automatic close_query();
		int dim;
		int k;
		int hd;
		int s;
		logic [63:0] key;
		cache_result_t res;
		dim = dim_now();
		k   = k_now();
		hd  = (dim < 16) ? dim : 16;
		for (int i = query_pos; i < hd; i++)
			query_key = query_key * 64'd31;
		for (int i = query_pos; i < 64; i++)
			query_vec[i] = '0;
		key       = query_key;
		query_pos = 0;
		query_key = '0;
		s = lookup_slot(key);
		if (s >= 0 && slot_k[s] == k && squared_gap(s, dim) <= longint'(thr_reg)) begin
			if (hits_seen != 32'hFFFF_FFFF)
				hits_seen++;
			promote_slot(s);
			for (int r = 0; r < k; r++) begin
				res.hit      = 1'b1;
				res.distance = slot_dist[s][r];
				res.label    = slot_label[s][r];
				res.fin      = (r + 1 == k);
				res.hits     = hits_seen;
				res.misses   = misses_seen;
				pending_results.push_back(res);
			end
			return;
		end
		if (misses_seen != 32'hFFFF_FFFF)
			misses_seen++;
		awaiting_fill = 1'b1;
		fills_seen    = 0;
		miss_key      = key;
		miss_k        = k;
		res.hit      = 1'b0;
		res.distance = '0;
		res.label    = '0;
		res.fin      = 1'b1;
		res.hits     = hits_seen;
		res.misses   = misses_seen;
		pending_results.push_back(res);
	endtask

	// Advance the shadow by one accepted transaction.
	task automatic apply_txn(cache_txn_t t);
		int dim;
		int hd;
		int scaled;
		case (t.kind)
			scq_pkg::KIND_CLEAR: begin
				for (int s = 0; s < 16; s++) begin
					slot_valid[s] = 1'b0;
					slot_age[s]   = 0;
				end
				hits_seen     = '0;
				misses_seen   = '0;
				awaiting_fill = 1'b0;
				fills_seen    = 0;
				query_pos     = 0;
				query_key     = '0;
			end
			scq_pkg::KIND_ELEM: begin
				if (!awaiting_fill) begin
					dim = dim_now();
					hd  = (dim < 16) ? dim : 16;
					query_vec[query_pos] = t.elem;
					if (query_pos < hd) begin
						// Element times 1000, truncated toward zero.
						scaled    = (int'($signed(t.elem)) * 125) / 32;
						query_key = query_key * 64'd31 + 64'(longint'(scaled));
					end
					query_pos++;
					if (t.fin || query_pos >= dim)
						close_query();
				end
			end
			scq_pkg::KIND_FILL: begin
				if (awaiting_fill) begin
					staged_dist[fills_seen]  = t.distance;
					staged_label[fills_seen] = t.label;
					fills_seen++;
					if (t.fin || fills_seen >= miss_k) begin
						for (int i = fills_seen; i < 16; i++) begin
							staged_dist[i]  = '0;
							staged_label[i] = 32'hFFFF_FFFF;
						end
						commit_fill();
						awaiting_fill = 1'b0;
						fills_seen    = 0;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Random pause after a transaction: mostly none or short, now and then long.
	task automatic idle_after_txn();
		int r;
		int gap;
		r = $urandom_range(99);
		if (skip_gaps || r < 55)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(3, 1);
		else
			gap = $urandom_range(30, 8);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Present one transaction and hold it until the block takes it.
	task automatic send_txn(logic [1:0] k, logic [15:0] e, logic [31:0] d,
			logic [31:0] l, logic f);
		cache_txn_t t;
		t.kind     = k;
		t.elem     = e;
		t.distance = d;
		t.label    = l;
		t.fin      = f;
		@(negedge clk);
		start         = 1'b1;
		kind          = k;
		query_element = e;
		fill_distance = d;
		fill_label    = l;
		last          = f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_txn(t);
		idle_after_txn();
	endtask

	task automatic send_elem(logic [15:0] e, logic f);
		send_txn(scq_pkg::KIND_ELEM, e, $urandom, $urandom, f);
	endtask

	task automatic send_fill(logic [31:0] d, logic [31:0] l, logic f);
		send_txn(scq_pkg::KIND_FILL, 16'($urandom), d, l, f);
	endtask

	// Wait until every queued result has come, then let any silent fill commit finish.
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		@(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	// Registers are only written once the block has gone quiet.
	task automatic write_reg(logic [1:0] idx, logic [47:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		case (idx)
			scq_pkg::CFG_CAPACITY:     cap_reg = value[4:0];
			scq_pkg::CFG_THRESHOLD:    thr_reg = value;
			scq_pkg::CFG_DIM_IN_USE:   dim_reg = value[6:0];
			scq_pkg::CFG_RESULT_COUNT: k_reg   = value[4:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(logic [47:0] cap, logic [47:0] thr, logic [47:0] dim,
			logic [47:0] k);
		drain();
		write_reg(scq_pkg::CFG_CAPACITY, cap);
		write_reg(scq_pkg::CFG_THRESHOLD, thr);
		write_reg(scq_pkg::CFG_DIM_IN_USE, dim);
		write_reg(scq_pkg::CFG_RESULT_COUNT, k);
	endtask

	// Directed: extremes of the fields, hit and miss, early ends of a query and of
	// a fill, ignored transactions, eviction under a tiny capacity and a clear.
	task automatic test_directed();
		configure(2, 0, 4, 3);
		send_elem(16'h7FFF, 1'b0);
		send_elem(16'h8000, 1'b0);
		send_elem(16'h0001, 1'b0);
		send_elem(16'hFFFF, 1'b1);
		send_fill(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_fill(32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
		send_fill(32'h8000_0001, 32'h0000_0000, 1'b0);
		// The same vector again must hit and return the three stored neighbors.
		send_elem(16'h7FFF, 1'b0);
		send_elem(16'h8000, 1'b0);
		send_elem(16'h0001, 1'b0);
		send_elem(16'hFFFF, 1'b0);
		// A short query ended by last; the missing elements count as zero.
		send_elem(16'h0000, 1'b0);
		send_elem(16'h0000, 1'b1);
		// While a fill is awaited, elements and the unused kind are dropped.
		send_elem(16'h1234, 1'b1);
		send_txn(KIND_IGNORED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_fill(32'h0000_5555, 32'h0000_0007, 1'b1);
		// A fill with nothing pending is dropped.
		send_fill(32'hAAAA_AAAA, 32'h0000_0001, 1'b1);
		// A third vector evicts the least recently used entry.
		send_elem(16'h0100, 1'b0);
		send_elem(16'hFF00, 1'b0);
		send_elem(16'h4000, 1'b0);
		send_elem(16'hC000, 1'b1);
		send_fill($urandom, $urandom, 1'b0);
		send_fill($urandom, $urandom, 1'b0);
		send_fill($urandom, $urandom, 1'b1);
		send_txn(scq_pkg::KIND_CLEAR, '0, '0, '0, 1'b0);
	endtask

	function automatic logic [15:0] random_elem();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'h7FFF;
		if (r == 1)
			return 16'h8000;
		if (r < 5)
			return 16'($signed($urandom_range(16, 0)) - 8);
		return 16'($urandom);
	endfunction

	task automatic refresh_pool();
		for (int p = 0; p < 6; p++)
			for (int i = 0; i < 64; i++)
				vec_pool[p][i] = random_elem();
	endtask

	// One random transaction or one whole query, chosen from the shadow's state.
	task automatic random_step(ref int sent);
		int r;
		int dim;
		int len;
		int p;
		int nudge;
		logic signed [15:0] v;
		r   = $urandom_range(99);
		dim = dim_now();
		if (r < 2) begin
			send_txn(scq_pkg::KIND_CLEAR, 16'($urandom), $urandom, $urandom, 1'($urandom));
			sent++;
		end else if (r < 5) begin
			send_txn(KIND_IGNORED, 16'($urandom), $urandom, $urandom, 1'($urandom));
			sent++;
		end else if (awaiting_fill) begin
			if (r < 10)
				send_elem(random_elem(), 1'($urandom));
			else
				send_fill($urandom, $urandom, ($urandom_range(9) == 0));
			sent++;
		end else if (r < 8) begin
			send_fill($urandom, $urandom, 1'($urandom));
			sent++;
		end else begin
			// Mostly pool vectors, sometimes with one element nudged, so hits,
			// near misses and threshold misses on a matching key all occur.
			p     = $urandom_range(5);
			nudge = ($urandom_range(3) == 0) ? $urandom_range(dim - 1) : -1;
			len   = ($urandom_range(7) == 0) ? $urandom_range(dim, 1) : dim;
			for (int i = 0; i < len; i++) begin
				v = (r < 85) ? vec_pool[p][i] : random_elem();
				if (i == nudge)
					v = v + 16'($urandom_range(40, 1));
				send_elem(v, (i == len - 1) ? ((len < dim) ? 1'b1 : 1'($urandom)) : 1'b0);
				sent++;
			end
		end
	endtask

	task automatic random_phase(int count);
		int sent;
		sent = 0;
		refresh_pool();
		skip_gaps = ($urandom_range(3) == 0);
		while (sent < count)
			random_step(sent);
		skip_gaps = 1'b0;
	endtask

	// Random traffic under several register settings, the clamped extremes among them.
	task automatic test_random();
		configure(16, 655, 4, 2);
		random_phase(80);
		configure(0, 0, 0, 0);
		random_phase(40);
		configure(3, 48'hFFFF_FFFF_FFFF, 20, 31);
		random_phase(80);
		configure(31, 1000000, 127, 0);
		random_phase(70);
		configure(2, 655, 8, 5);
		random_phase(80);
		configure(5, 48'hFFFF_FFFF_FFFF, 1, 16);
		random_phase(30);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Every strobed result is checked against the oldest outstanding expectation.
	always @(posedge clk) begin
		cache_result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual hit=%b distance=%h",
					$time, hit, out_distance);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("out_distance", want.distance, out_distance);
				check_field("out_label", want.label, out_label);
				check_field("last_result", 32'(want.fin), 32'(last_result));
				check_field("hit_count", want.hits, hit_count);
				check_field("miss_count", want.misses, miss_count);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_similarity_query_result_cache_top: errors");
			$finish;
		end
	end

	initial begin
		errors        = 0;
		cycles        = 0;
		skip_gaps     = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		kind          = scq_pkg::KIND_ELEM;
		query_element = '0;
		fill_distance = '0;
		fill_label    = '0;
		last          = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = scq_pkg::CFG_CAPACITY;
		cfg_data      = '0;
		reset_shadow();
		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random();

		// Let the last results and any silent fill commit run out.
		drain();
		if (errors == 0)
			$display("tb_similarity_query_result_cache_top: clean");
		else
			$display("tb_similarity_query_result_cache_top: errors");
		$finish;
	end

endmodule
`default_nettype wire
